// ----- hdl/ray_sphere_intersection_defines.svh -----
// Assertion macros shared by the ray/sphere block.
// Each macro expects signals named clock and reset in the enclosing module.
`ifndef RAY_SPHERE_INTERSECTION_DEFINES_SVH
`define RAY_SPHERE_INTERSECTION_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define RSI_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger
`define RSI_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its trigger
`define RSI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/rsi_pkg.sv -----
package rsi_pkg;

   // Field width of every coordinate and of the configuration data
   localparam int COORD_W = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int MUL_CHUNK_DEF = 32;
   localparam int CSR_INDEX_W = 2;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type origin_x;
      coord_type origin_y;
      coord_type origin_z;
      coord_type dir_x;
      coord_type dir_y;
      coord_type dir_z;
   } req_payload_type;

   typedef struct packed {
      logic               hit;
      logic [COORD_W-2:0] distance;
   } rsp_payload_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Y = 2'd1,
      CSR_CENTER_Z = 2'd2,
      CSR_RADIUS   = 2'd3
   } csr_index_type;

endpackage

// ----- hdl/rsi_mul.sv -----
module rsi_mul #(
   parameter int A_W = 65,
   parameter int B_W = 65,
   parameter int CHUNK = 32,
   parameter int DEPTH = 9,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [A_W-1:0]   in_a,
   input  logic [B_W-1:0]   in_b,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [A_W+B_W-1:0] out_p,
   output logic [TAG_W-1:0] out_tag
);

   localparam int NA = (A_W + CHUNK - 1) / CHUNK;
   localparam int NB = (B_W + CHUNK - 1) / CHUNK;
   localparam int NP = NA * NB;
   localparam int AP_W = NA * CHUNK;
   localparam int BP_W = NB * CHUNK;
   localparam int P_W = A_W + B_W;
   localparam int EXT_W = AP_W + BP_W;

   logic             valid_ff [DEPTH];
   logic [AP_W-1:0]  a_ff [DEPTH];
   logic [BP_W-1:0]  b_ff [DEPTH];
   logic [P_W-1:0]   acc_ff [DEPTH];
   logic [TAG_W-1:0] tag_ff [DEPTH];

   // One chunk-by-chunk product per stage until all are summed in place
   for (genvar s = 0; s < DEPTH; s++) begin : g_stage
      logic             valid_src;
      logic [AP_W-1:0]  a_src;
      logic [BP_W-1:0]  b_src;
      logic [P_W-1:0]   acc_src;
      logic [P_W-1:0]   acc_in;
      logic [TAG_W-1:0] tag_src;

      if (s == 0) begin : g_first
         assign valid_src = in_valid;
         assign a_src = AP_W'(in_a);
         assign b_src = BP_W'(in_b);
         assign acc_src = '0;
         assign tag_src = in_tag;
      end else begin : g_next
         assign valid_src = valid_ff[s-1];
         assign a_src = a_ff[s-1];
         assign b_src = b_ff[s-1];
         assign acc_src = acc_ff[s-1];
         assign tag_src = tag_ff[s-1];
      end

      if (s < NP) begin : g_pp
         localparam int I = s / NB;
         localparam int J = s % NB;
         logic [2*CHUNK-1:0] pp;
         logic [EXT_W-1:0]   pp_sh;
         assign pp = a_src[I*CHUNK +: CHUNK] * b_src[J*CHUNK +: CHUNK];
         assign pp_sh = EXT_W'(pp) << ((I + J) * CHUNK);
         assign acc_in = acc_src + pp_sh[P_W-1:0];
      end else begin : g_pass
         assign acc_in = acc_src;
      end

      // Advance valid with the stage
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= valid_src;
         end
      end

      // Advance operands and running sum
      always_ff @(posedge clock) begin
         if (en) begin
            a_ff[s] <= a_src;
            b_ff[s] <= b_src;
            acc_ff[s] <= acc_in;
            tag_ff[s] <= tag_src;
         end
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_p = acc_ff[DEPTH-1];
   assign out_tag = tag_ff[DEPTH-1];

endmodule

// ----- hdl/rsi_div.sv -----
module rsi_div #(
   parameter int N_W = 83,
   parameter int D_W = 64,
   parameter int Q_W = 31,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [N_W-1:0]   in_n,
   input  logic [D_W-1:0]   in_d,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [Q_W-1:0]   out_q,
   output logic [TAG_W-1:0] out_tag
);

   localparam int X_W = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;
   localparam int NS = Q_W + 1;

   logic             valid_ff [NS];
   logic [X_W-1:0]   n_ff [NS];
   logic [X_W-1:0]   d_ff [NS];
   logic [Q_W-1:0]   q_ff [NS];
   logic             sat_ff [NS];
   logic [TAG_W-1:0] tag_ff [NS];

   // First stage flags overflow, each later stage settles one quotient bit
   for (genvar j = 0; j < NS; j++) begin : g_stage
      logic             valid_src;
      logic [X_W-1:0]   n_in;
      logic [X_W-1:0]   d_in;
      logic [Q_W-1:0]   q_in;
      logic             sat_in;
      logic [TAG_W-1:0] tag_src;

      if (j == 0) begin : g_sat
         assign valid_src = in_valid;
         assign n_in = X_W'(in_n);
         assign d_in = X_W'(in_d);
         assign q_in = '0;
         assign sat_in = (X_W'(in_n) >= (X_W'(in_d) << Q_W));
         assign tag_src = in_tag;
      end else begin : g_bit
         localparam int K = Q_W - j;
         logic [X_W-1:0] dk;
         logic           ge;
         assign dk = d_ff[j-1] << K;
         assign ge = (n_ff[j-1] >= dk);
         assign valid_src = valid_ff[j-1];
         assign n_in = ge ? n_ff[j-1] - dk : n_ff[j-1];
         assign d_in = d_ff[j-1];
         assign q_in = ge ? (q_ff[j-1] | (Q_W'(1) << K)) : q_ff[j-1];
         assign sat_in = sat_ff[j-1];
         assign tag_src = tag_ff[j-1];
      end

      // Advance valid with the stage
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (en) begin
            valid_ff[j] <= valid_src;
         end
      end

      // Advance remainder and partial quotient
      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[j] <= n_in;
            d_ff[j] <= d_in;
            q_ff[j] <= q_in;
            sat_ff[j] <= sat_in;
            tag_ff[j] <= tag_src;
         end
      end
   end

   // Clamp overflowed quotients to all ones
   assign out_valid = valid_ff[NS-1];
   assign out_q = sat_ff[NS-1] ? '1 : q_ff[NS-1];
   assign out_tag = tag_ff[NS-1];

endmodule

// ----- hdl/ray_sphere_intersection.sv -----
// Ray against sphere intersection engine.
// The req channel takes one ray (origin and direction, signed Q16.16) per item;
// the rsp channel returns one item per ray: a hit flag and the nearest
// non-negative distance, unsigned Q15.16, saturated, zero on a miss.
// The csr channel writes the sphere centre (index 0 to 2) and radius (index 3);
// it is always ready and should be used only while no ray is in flight.
// One ray enters per cycle while req_ready is high. The default widths give
// 4 front stages (difference, products, sums, magnitudes), 9 stages of chunked
// wide multiply for h*h and a*c, 1 stage for the discriminant, 66 square root
// stages (one root bit each), 1 stage for q, 32 divider stages (overflow check,
// then one quotient bit each) and the output buffer.
// Results collect in a two-entry output buffer. When rsp_ready stays low the
// buffer fills and the whole pipeline holds, dropping req_ready; no item is
// lost or repeated. Reset empties the pipeline and buffer, sets the centre to
// zero and the radius to 1.0.
`include "ray_sphere_intersection_defines.svh"

module ray_sphere_intersection #(
   parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF,
   parameter int MUL_CHUNK = rsi_pkg::MUL_CHUNK_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  rsi_pkg::req_payload_type      req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rsi_pkg::rsp_payload_type      rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  rsi_pkg::csr_index_type        csr_index,
   input  logic [rsi_pkg::COORD_W-1:0]   csr_wdata
);

   import rsi_pkg::*;

   localparam int CW = COORD_W;
   localparam int LW = CW + 1;
   localparam int R_W = CW - 1;
   localparam int DD_W = 2 * CW;
   localparam int DL_W = 2 * CW + 1;
   localparam int A_W = 2 * CW;
   localparam int H_W = 2 * CW + 2;
   localparam int HM_W = 2 * CW + 1;
   localparam int C_W = 2 * CW + 3;
   localparam int CM_W = 2 * CW + 2;
   localparam int HH_W = 2 * HM_W;
   localparam int AC_W = A_W + CM_W;
   localparam int SW = 2 * CW + 2;
   localparam int SX_W = 2 * SW;
   localparam int RW = SW + 3;
   localparam int QM_W = 2 * CW + 3;
   localparam int N0_W = QM_W + FRAC_BITS;
   localparam int N1_W = CM_W + FRAC_BITS;
   localparam int Q_W = CW - 1;
   localparam int NC_H = (HM_W + MUL_CHUNK - 1) / MUL_CHUNK;
   localparam int NC_A = (A_W + MUL_CHUNK - 1) / MUL_CHUNK;
   localparam int NC_C = (CM_W + MUL_CHUNK - 1) / MUL_CHUNK;
   localparam int MUL_DEPTH = (NC_H * NC_H > NC_A * NC_C) ? NC_H * NC_H : NC_A * NC_C;

   typedef struct packed {
      logic [A_W-1:0]  a;
      logic [HM_W-1:0] hmag;
      logic [CM_W-1:0] cmag;
      logic            c_neg;
      logic            c_zero;
      logic            h_pos;
      logic            a_zero;
      logic            disc_neg;
      logic            disc_zero;
   } ctx_type;

   typedef struct packed {
      logic live;
      logic ok0;
      logic ok1;
   } fin_type;

   localparam int CTX_W = $bits(ctx_type);
   localparam int FIN_W = $bits(fin_type);

   // ---------------- configuration ----------------
   coord_type      center_x_ff;
   coord_type      center_y_ff;
   coord_type      center_z_ff;
   logic [R_W-1:0] radius_ff;

   assign csr_ready = 1'b1;

   // Write one register per handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
         radius_ff <= R_W'(1) << FRAC_BITS;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CENTER_X: center_x_ff <= csr_wdata;
            CSR_CENTER_Y: center_y_ff <= csr_wdata;
            CSR_CENTER_Z: center_z_ff <= csr_wdata;
            CSR_RADIUS:   radius_ff <= csr_wdata[R_W-1:0];
            default:      radius_ff <= radius_ff;
         endcase
      end
   end

   // ---------------- flow control ----------------
   logic       adv;
   logic [1:0] fifo_cnt_ff;

   assign adv = (fifo_cnt_ff != 2'd2);
   assign req_ready = adv;

   // ---------------- stage 1: L = O - C ----------------
   logic                 s1_valid_ff;
   logic signed [LW-1:0] s1_l_ff [3];
   coord_type            s1_d_ff [3];
   logic [R_W-1:0]       s1_r_ff;
   coord_type            org [3];
   coord_type            ctr [3];

   assign org[0] = req_data.origin_x;
   assign org[1] = req_data.origin_y;
   assign org[2] = req_data.origin_z;
   assign ctr[0] = center_x_ff;
   assign ctr[1] = center_y_ff;
   assign ctr[2] = center_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            s1_l_ff[k] <= LW'(org[k]) - LW'(ctr[k]);
         end
         s1_d_ff[0] <= req_data.dir_x;
         s1_d_ff[1] <= req_data.dir_y;
         s1_d_ff[2] <= req_data.dir_z;
         s1_r_ff <= radius_ff;
      end
   end

   // ---------------- stage 2: lane products ----------------
   logic                   s2_valid_ff;
   logic signed [DD_W-1:0] s2_dd_ff [3];
   logic signed [DL_W-1:0] s2_dl_ff [3];
   logic signed [DL_W-1:0] s2_ll_ff [3];
   logic [2*R_W-1:0]       s2_rr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            s2_dd_ff[k] <= DD_W'(s1_d_ff[k]) * DD_W'(s1_d_ff[k]);
            s2_dl_ff[k] <= DL_W'(s1_d_ff[k]) * DL_W'(s1_l_ff[k]);
            s2_ll_ff[k] <= DL_W'(s1_l_ff[k]) * DL_W'(s1_l_ff[k]);
         end
         s2_rr_ff <= (2*R_W)'(s1_r_ff) * (2*R_W)'(s1_r_ff);
      end
   end

   // ---------------- stage 3: a, h, c ----------------
   logic                  s3_valid_ff;
   logic [A_W-1:0]        s3_a_ff;
   logic signed [H_W-1:0] s3_h_ff;
   logic signed [C_W-1:0] s3_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_a_ff <= A_W'(s2_dd_ff[0]) + A_W'(s2_dd_ff[1]) + A_W'(s2_dd_ff[2]);
         s3_h_ff <= H_W'(s2_dl_ff[0]) + H_W'(s2_dl_ff[1]) + H_W'(s2_dl_ff[2]);
         s3_c_ff <= C_W'(s2_ll_ff[0]) + C_W'(s2_ll_ff[1]) + C_W'(s2_ll_ff[2])
                    - C_W'(s2_rr_ff);
      end
   end

   // ---------------- stage 4: magnitudes and signs ----------------
   logic    s4_valid_ff;
   ctx_type s4_ctx_ff;
   ctx_type s4_ctx_in;
   logic [H_W-1:0] h_abs;
   logic [C_W-1:0] c_abs;

   always_comb begin
      h_abs = s3_h_ff[H_W-1] ? -s3_h_ff : s3_h_ff;
      c_abs = s3_c_ff[C_W-1] ? -s3_c_ff : s3_c_ff;
      s4_ctx_in.a = s3_a_ff;
      s4_ctx_in.hmag = h_abs[HM_W-1:0];
      s4_ctx_in.cmag = c_abs[CM_W-1:0];
      s4_ctx_in.c_neg = s3_c_ff[C_W-1];
      s4_ctx_in.c_zero = (s3_c_ff == '0);
      s4_ctx_in.h_pos = !s3_h_ff[H_W-1] && (s3_h_ff != '0);
      s4_ctx_in.a_zero = (s3_a_ff == '0);
      s4_ctx_in.disc_neg = 1'b0;
      s4_ctx_in.disc_zero = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_ctx_ff <= s4_ctx_in;
      end
   end

   // ---------------- wide products h*h and a*|c| ----------------
   logic            hh_valid;
   logic [HH_W-1:0] hh_p;
   ctx_type         hh_ctx;
   logic            ac_valid;
   logic [AC_W-1:0] ac_p;

   rsi_mul #(
      .A_W(HM_W), .B_W(HM_W), .CHUNK(MUL_CHUNK), .DEPTH(MUL_DEPTH), .TAG_W(CTX_W)
   ) u_mul_hh (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(s4_valid_ff), .in_a(s4_ctx_ff.hmag), .in_b(s4_ctx_ff.hmag),
      .in_tag(s4_ctx_ff),
      .out_valid(hh_valid), .out_p(hh_p), .out_tag(hh_ctx)
   );

   rsi_mul #(
      .A_W(A_W), .B_W(CM_W), .CHUNK(MUL_CHUNK), .DEPTH(MUL_DEPTH), .TAG_W(1)
   ) u_mul_ac (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(s4_valid_ff), .in_a(s4_ctx_ff.a), .in_b(s4_ctx_ff.cmag),
      .in_tag(1'b0),
      .out_valid(ac_valid), .out_p(ac_p), .out_tag()
   );

   // ---------------- stage 5: discriminant ----------------
   logic                   ds_valid_ff;
   logic [SX_W-1:0]        ds_x_ff;
   ctx_type                ds_ctx_ff;
   logic signed [SX_W-1:0] disc;
   ctx_type                ds_ctx_in;

   always_comb begin
      disc = hh_ctx.c_neg ? SX_W'(hh_p) + SX_W'(ac_p) : SX_W'(hh_p) - SX_W'(ac_p);
      ds_ctx_in = hh_ctx;
      ds_ctx_in.disc_neg = disc[SX_W-1];
      ds_ctx_in.disc_zero = (disc == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ds_valid_ff <= 1'b0;
      end else if (adv) begin
         ds_valid_ff <= hh_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ds_x_ff <= disc;
         ds_ctx_ff <= ds_ctx_in;
      end
   end

   // ---------------- square root, one root bit per stage ----------------
   logic            sq_valid_ff [SW];
   logic [SX_W-1:0] sq_x_ff [SW];
   logic [RW-1:0]   sq_rem_ff [SW];
   logic [SW-1:0]   sq_root_ff [SW];
   ctx_type         sq_ctx_ff [SW];

   for (genvar i = 0; i < SW; i++) begin : g_sqrt
      localparam int P = SW - 1 - i;
      logic            valid_src;
      logic [SX_W-1:0] x_src;
      logic [RW-1:0]   rem_src;
      logic [SW-1:0]   root_src;
      ctx_type         ctx_src;
      logic [RW-1:0]   rem_sh;
      logic [RW-1:0]   trial;
      logic            ge;

      if (i == 0) begin : g_first
         assign valid_src = ds_valid_ff;
         assign x_src = ds_x_ff;
         assign rem_src = '0;
         assign root_src = '0;
         assign ctx_src = ds_ctx_ff;
      end else begin : g_next
         assign valid_src = sq_valid_ff[i-1];
         assign x_src = sq_x_ff[i-1];
         assign rem_src = sq_rem_ff[i-1];
         assign root_src = sq_root_ff[i-1];
         assign ctx_src = sq_ctx_ff[i-1];
      end

      // Bring down the next bit pair and try root*4+1
      assign rem_sh = {rem_src[RW-3:0], x_src[2*P +: 2]};
      assign trial = RW'({root_src, 2'b01});
      assign ge = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[i] <= 1'b0;
         end else if (adv) begin
            sq_valid_ff[i] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_x_ff[i] <= x_src;
            sq_rem_ff[i] <= ge ? rem_sh - trial : rem_sh;
            sq_root_ff[i] <= {root_src[SW-2:0], ge};
            sq_ctx_ff[i] <= ctx_src;
         end
      end
   end

   // ---------------- stage 6: q and root operands ----------------
   logic            q_valid_ff;
   logic [N0_W-1:0] n0_ff;
   logic [A_W-1:0]  d0_ff;
   logic [N1_W-1:0] n1_ff;
   logic [QM_W-1:0] d1_ff;
   fin_type         fin_ff;
   ctx_type         sq_ctx;
   logic [QM_W-1:0] qmag;

   // |q| = sqrt(disc) + |h| whatever the sign of h
   assign sq_ctx = sq_ctx_ff[SW-1];
   assign qmag = QM_W'(sq_root_ff[SW-1]) + QM_W'(sq_ctx.hmag);

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else if (adv) begin
         q_valid_ff <= sq_valid_ff[SW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n0_ff <= N0_W'(qmag) << FRAC_BITS;
         d0_ff <= sq_ctx.a;
         n1_ff <= N1_W'(sq_ctx.cmag) << FRAC_BITS;
         d1_ff <= qmag;
         fin_ff.live <= !sq_ctx.a_zero && !sq_ctx.disc_neg;
         fin_ff.ok0 <= !sq_ctx.h_pos;
         fin_ff.ok1 <= !sq_ctx.disc_zero
                       && (sq_ctx.c_zero || (sq_ctx.c_neg == sq_ctx.h_pos));
      end
   end

   // ---------------- roots q/a and c/q ----------------
   logic           dv0_valid;
   logic [Q_W-1:0] v0;
   fin_type        dv_fin;
   logic           dv1_valid;
   logic [Q_W-1:0] v1;

   rsi_div #(
      .N_W(N0_W), .D_W(A_W), .Q_W(Q_W), .TAG_W(FIN_W)
   ) u_div_qa (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(q_valid_ff), .in_n(n0_ff), .in_d(d0_ff), .in_tag(fin_ff),
      .out_valid(dv0_valid), .out_q(v0), .out_tag(dv_fin)
   );

   rsi_div #(
      .N_W(N1_W), .D_W(QM_W), .Q_W(Q_W), .TAG_W(1)
   ) u_div_cq (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(q_valid_ff), .in_n(n1_ff), .in_d(d1_ff), .in_tag(1'b0),
      .out_valid(dv1_valid), .out_q(v1), .out_tag()
   );

   // ---------------- pick the nearest root ----------------
   rsp_payload_type result;

   always_comb begin
      result.hit = dv_fin.live && (dv_fin.ok0 || dv_fin.ok1);
      if (!result.hit) begin
         result.distance = '0;
      end else if (dv_fin.ok0 && dv_fin.ok1) begin
         result.distance = (v0 < v1) ? v0 : v1;
      end else if (dv_fin.ok0) begin
         result.distance = v0;
      end else begin
         result.distance = v1;
      end
   end

   // ---------------- two-entry output buffer ----------------
   rsp_payload_type fifo_ff [2];
   logic            wr_ptr_ff;
   logic            rd_ptr_ff;
   logic            push;
   logic            pop;

   assign push = adv && dv0_valid;
   assign pop = rsp_valid && rsp_ready;
   assign rsp_valid = (fifo_cnt_ff != 2'd0);
   assign rsp_data = fifo_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fifo_cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   fifo_cnt_ff <= fifo_cnt_ff + 2'd1;
            2'b01:   fifo_cnt_ff <= fifo_cnt_ff - 2'd1;
            default: fifo_cnt_ff <= fifo_cnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= result;
      end
   end

   // ---------------- assertions ----------------
   `RSI_ASSERT_ALWAYS(a_mul_align, hh_valid == ac_valid, "product pipelines out of step")
   `RSI_ASSERT_ALWAYS(a_div_align, dv0_valid == dv1_valid, "divider pipelines out of step")
   `RSI_ASSERT_ALWAYS(a_fifo_bound, fifo_cnt_ff != 2'd3, "output buffer overfilled")
   `RSI_ASSERT_IMPLY(a_miss_zero, rsp_valid && !rsp_data.hit, rsp_data.distance == '0, "miss with nonzero distance")

endmodule

// ----- tb/sv/ray_sphere_intersection_tb.sv -----
module ray_sphere_intersection_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rsi_pkg::*;

   localparam int ONE        = 65536;
   localparam int LATENCY    = 114;
   localparam int CYCLE_LIMIT = 600000;
   localparam logic [30:0] DIST_MAX = 31'h7fffffff;

   typedef logic signed [255:0] wide_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_payload_type  req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rsp_payload_type  rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   csr_index_type    csr_index;
   logic [COORD_W-1:0] csr_wdata;

   // sphere as the block should currently see it
   coord_type        sphere_cx, sphere_cy, sphere_cz;
   logic [30:0]      sphere_r;

   rsp_payload_type  pending_hits[$];
   int               error_count;
   int               cycle_count;
   int               send_idle_pct;
   int               recv_idle_pct;
   int               stall_request;
   int               stall_left;

   ray_sphere_intersection uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // floor square root, one result bit per pass
   function automatic logic [255:0] floor_sqrt(input logic [255:0] x);
      logic [255:0] res;
      logic [255:0] bitv;
      res  = '0;
      bitv = 256'd1 << 254;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // non-negative root num/den, quantized to unsigned Q15.16 and saturated
   function automatic bit root_distance(input wide_type num, input wide_type den,
                                        output logic [30:0] quant);
      logic [255:0] mag_n, mag_d, quo;
      quant = '0;
      if (den == 0) return 1'b0;
      if (num != 0 && num[255] != den[255]) return 1'b0;
      mag_n = num[255] ? -num : num;
      mag_d = den[255] ? -den : den;
      quo   = (mag_n << 16) / mag_d;
      quant = (quo > DIST_MAX) ? DIST_MAX : quo[30:0];
      return 1'b1;
   endfunction

   function automatic rsp_payload_type trace_ray(input req_payload_type ray);
      wide_type lx, ly, lz, dx, dy, dz, rad, a, h, c, disc, s, q;
      logic [30:0] t0, t1;
      bit ok0, ok1;
      rsp_payload_type res;
      res = '0;
      dx  = $signed(ray.dir_x);
      dy  = $signed(ray.dir_y);
      dz  = $signed(ray.dir_z);
      lx  = $signed(ray.origin_x);
      ly  = $signed(ray.origin_y);
      lz  = $signed(ray.origin_z);
      lx  = lx - $signed(sphere_cx);
      ly  = ly - $signed(sphere_cy);
      lz  = lz - $signed(sphere_cz);
      rad = {225'd0, sphere_r};
      a   = dx * dx + dy * dy + dz * dz;
      h   = dx * lx + dy * ly + dz * lz;
      c   = lx * lx + ly * ly + lz * lz - rad * rad;
      if (a != 0) begin
         disc = h * h - a * c;
         if (disc == 0) begin
            res.hit = root_distance(-h, a, t0);
            res.distance = t0;
         end else if (!disc[255]) begin
            s   = floor_sqrt(disc);
            q   = (!h[255] && h != 0) ? -(h + s) : s - h;
            ok0 = root_distance(q, a, t0);
            ok1 = root_distance(c, q, t1);
            if (ok0 && ok1) begin
               res.hit = 1'b1;
               res.distance = (t0 < t1) ? t0 : t1;
            end else if (ok0) begin
               res.hit = 1'b1;
               res.distance = t0;
            end else if (ok1) begin
               res.hit = 1'b1;
               res.distance = t1;
            end
         end
      end
      if (!res.hit) res.distance = '0;
      return res;
   endfunction

   // cycle budget
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // drive rsp_ready: random stalls, or a long hold-off on request
   always @(posedge clock) begin
      if (stall_request > 0) begin
         stall_left    <= stall_request;
         stall_request <= 0;
         rsp_ready     <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // compare each result item with the oldest prediction
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_hits.size() == 0) begin
            $display("%0t: unexpected result item hit=%0b dist=%h", $realtime,
                     rsp_data.hit, rsp_data.distance);
            error_count++;
         end else begin
            want = pending_hits.pop_front();
            if (rsp_data.hit !== want.hit) begin
               $display("%0t: hit mismatch expected %0b actual %0b", $realtime,
                        want.hit, rsp_data.hit);
               error_count++;
            end
            if (rsp_data.distance !== want.distance) begin
               $display("%0t: distance mismatch expected %h actual %h", $realtime,
                        want.distance, rsp_data.distance);
               error_count++;
            end
         end
      end
   end

   task automatic send_ray(input req_payload_type ray);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ray;
      do @(posedge clock); while (!req_ready);
      pending_hits.push_back(trace_ray(ray));
   endtask

   // drop valid and wait for every outstanding result item
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (LATENCY / 10) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [COORD_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_CENTER_X: sphere_cx = val;
         CSR_CENTER_Y: sphere_cy = val;
         CSR_CENTER_Z: sphere_cz = val;
         default:      sphere_r  = val[30:0];
      endcase
      @(posedge clock);
   endtask

   task automatic set_sphere(input coord_type x, input coord_type y, input coord_type z,
                             input logic [COORD_W-1:0] r);
      write_csr(CSR_CENTER_X, x);
      write_csr(CSR_CENTER_Y, y);
      write_csr(CSR_CENTER_Z, z);
      write_csr(CSR_RADIUS, r);
   endtask

   function automatic req_payload_type make_ray(input int ox, input int oy, input int oz,
                                                input int vx, input int vy, input int vz);
      req_payload_type ray;
      ray.origin_x = ox;
      ray.origin_y = oy;
      ray.origin_z = oz;
      ray.dir_x    = vx;
      ray.dir_y    = vy;
      ray.dir_z    = vz;
      return ray;
   endfunction

   // mostly rays aimed near the sphere, the rest raw bit patterns
   function automatic req_payload_type random_ray;
      req_payload_type ray;
      int span;
      if ($urandom_range(3) == 0) begin
         ray = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end else begin
         span = 8 * ONE;
         ray.origin_x = sphere_cx + $urandom_range(0, 2 * span) - span;
         ray.origin_y = sphere_cy + $urandom_range(0, 2 * span) - span;
         ray.origin_z = sphere_cz + $urandom_range(0, 2 * span) - span;
         ray.dir_x = sphere_cx - ray.origin_x + $urandom_range(0, 2 * ONE) - ONE;
         ray.dir_y = sphere_cy - ray.origin_y + $urandom_range(0, 2 * ONE) - ONE;
         ray.dir_z = sphere_cz - ray.origin_z + $urandom_range(0, 2 * ONE) - ONE;
         if ($urandom_range(4) == 0) ray.dir_x = -ray.dir_x;
         if ($urandom_range(7) == 0) ray.dir_y = $urandom_range(0, 3) - 1;
      end
      return ray;
   endfunction

   task automatic test_directed;
      // default sphere: unit radius at the origin
      send_ray(make_ray(0, 0, -5 * ONE, 0, 0, ONE));
      send_ray(make_ray(0, 0, -5 * ONE, 0, 0, 0));
      send_ray(make_ray(3 * ONE, 0, -5 * ONE, 0, 0, ONE));
      send_ray(make_ray(0, 0, 0, ONE, 0, 0));
      send_ray(make_ray(ONE, 0, -5 * ONE, 0, 0, ONE));
      send_ray(make_ray(ONE, 0, 5 * ONE, 0, 0, ONE));
      send_ray(make_ray(0, 0, 5 * ONE, 0, 0, ONE));
      send_ray(make_ray(0, 0, -ONE, 0, 0, -ONE));
      send_ray(make_ray(0, 0, -ONE, 0, 0, ONE));
      send_ray(make_ray(0, 0, -30000 * ONE, 0, 0, 1));
      send_ray(make_ray(0, 0, -5 * ONE, 0, 0, -1));
      send_ray(make_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                        32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
      send_ray(make_ray(32'h80000000, 32'h80000000, 32'h80000000,
                        32'h80000000, 32'h80000000, 32'h80000000));
      send_ray(make_ray(32'h80000000, 32'h80000000, 32'h80000000,
                        32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
      send_ray(make_ray(32'h7fffffff, 0, 0, 32'h80000000, 0, 0));
      send_ray(make_ray(-1, -1, -1, 1, 1, 1));
      drain();
   endtask

   task automatic test_sphere_settings;
      set_sphere(32'h7fffffff, 32'h80000000, 0, 32'h7fffffff);
      send_ray(make_ray(0, 0, 0, ONE, 0, 0));
      send_ray(make_ray(32'h7fffffff, 32'h80000000, 0, 0, ONE, 0));
      send_ray(make_ray(32'h80000000, 32'h7fffffff, 32'h7fffffff, ONE, -ONE, 1));
      drain();
      set_sphere(32'h80000000, 32'h7fffffff, 32'h80000000, 32'hffffffff);
      send_ray(make_ray(32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0, 1));
      send_ray(make_ray(0, 0, 0, -ONE, ONE, -ONE));
      drain();
      // zero radius: only a ray through the exact centre hits
      set_sphere(2 * ONE, -3 * ONE, ONE, 0);
      send_ray(make_ray(2 * ONE, -3 * ONE, -4 * ONE, 0, 0, ONE));
      send_ray(make_ray(2 * ONE, -3 * ONE, -4 * ONE, 0, 1, ONE));
      drain();
   endtask

   task automatic test_random(input int count, input int snd_pct, input int rcv_pct);
      send_idle_pct = snd_pct;
      recv_idle_pct = rcv_pct;
      for (int i = 0; i < count; i++) begin
         // retune the sphere now and then, only when idle
         if (i % 120 == 60) begin
            drain();
            set_sphere($urandom_range(0, 40 * ONE) - 20 * ONE,
                       $urandom_range(0, 40 * ONE) - 20 * ONE,
                       ($urandom_range(1) == 0) ? $urandom : 0,
                       $urandom_range(0, 6 * ONE));
         end
         send_ray(random_ray());
      end
      drain();
   endtask

   task automatic test_backpressure;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_sphere(0, 0, 0, 3 * ONE);
      stall_request = 400;
      for (int i = 0; i < 200; i++) send_ray(random_ray());
      drain();
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_ready     = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = CSR_CENTER_X;
      csr_wdata     = '0;
      error_count   = 0;
      cycle_count   = 0;
      stall_request = 0;
      stall_left    = 0;
      send_idle_pct = 8;
      recv_idle_pct = 69;
      sphere_cx     = '0;
      sphere_cy     = '0;
      sphere_cz     = '0;
      sphere_r      = ONE;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_sphere_settings();
      set_sphere(0, 0, 0, 2 * ONE);
      test_random(300, 8, 69);
      test_random(300, 69, 8);
      test_random(300, 0, 0);
      test_backpressure();

      repeat (LATENCY + 20) @(posedge clock);
      if (error_count == 0 && pending_hits.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
